@@ hw/rtl/fst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fst_pkg;
  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CFG_AW = 4;

  localparam logic [31:0] SIG_FIRST_RST  = 32'hDEADBEEF;
  localparam logic [31:0] SIG_SECOND_RST = 32'h909090C3;
  localparam logic [31:0] SIG_MIXED_RST  = 32'hCAFEBABE;
  localparam logic [1:0]  COUNT_MAX      = 2'd3;

  typedef enum logic [1:0] {
    OP_STORE   = 2'd0,
    OP_CHECK   = 2'd1,
    OP_PEEK    = 2'd2,
    OP_CONSUME = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    OUT_OK        = 2'd0,
    OUT_NOT_FOUND = 2'd1,
    OUT_FULL      = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    REG_SIG_FIRST  = 2'd0,
    REG_SIG_SECOND = 2'd1,
    REG_SIG_MIXED  = 2'd2
  } reg_idx_t;

  localparam logic [1:0] SEL_FIRST  = 2'd1;
  localparam logic [1:0] SEL_SECOND = 2'd2;
  localparam logic [1:0] SEL_MIXED  = 2'd3;

  // lookup token walking down the row of cells
  typedef struct packed {
    logic             vld;
    logic [1:0]       op;
    logic [31:0]      key;
    logic [31:0]      w0;
    logic [31:0]      w1;
    logic [1:0]       sel;
    logic             hit;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
    logic [1:0]       count;
    logic             flag;
  } token_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      key;
    logic [31:0]      w0;
    logic [31:0]      w1;
  } claim_t;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
    logic [31:0] mixed;
  } sigs_t;
endpackage
`default_nettype wire

@@ hw/rtl/fst_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface fst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] flow_key;
  logic [31:0] payload_zero;
  logic [31:0] payload_one;
  logic [1:0]  check_select;
  modport source(output valid, op, flow_key, payload_zero, payload_one, check_select,
                 input ready);
  modport sink(input valid, op, flow_key, payload_zero, payload_one, check_select,
               output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fst_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface fst_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic [1:0] checks_done;
  logic       flagged;
  modport source(output valid, outcome, checks_done, flagged, input ready);
  modport sink(input valid, outcome, checks_done, flagged, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/flow_status_table.sv @@
// Flow status table: 64 fully associative entries held in a row of cells.
// Each transaction enters the first cell and moves one cell per cycle, looking
// up the key and noting the lowest free slot on its way; a store of a new key
// claims that slot when the result leaves the tail register. The result passes
// through the cell row, the tail register and the output register, and one item
// is in the row at a time. A new item may be accepted while the previous result
// still waits on the output. Signature registers sit at byte addresses 0, 4 and
// 8; the user must write them only while idle, and the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module flow_status_table (
  input  wire                          clk,
  input  wire                          rst_n,
  fst_in_if.sink                       in_ch,
  fst_out_if.source                    out_ch,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [fst_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire  [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  fst_pkg::token_t links [0:fst_pkg::ENTRIES];
  fst_pkg::token_t tail_r;
  fst_pkg::claim_t claim;
  fst_pkg::sigs_t  sigs_r;
  logic busy_r, busy_nxt, tail_vld_r, tail_vld_nxt, out_vld_r, out_vld_nxt;
  logic [1:0] outcome_r, outcome_nxt, count_r, count_nxt;
  logic flag_r, flag_nxt;
  logic accept, moving, cfg_wr;
  logic [1:0] reg_idx;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy_r;

  assign links[0] = '{vld: accept, op: in_ch.op, key: in_ch.flow_key,
                      w0: in_ch.payload_zero, w1: in_ch.payload_one,
                      sel: in_ch.check_select, default: '0};

  for (genvar g = 0; g < fst_pkg::ENTRIES; g++) begin : g_cell
    fst_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx_i   (fst_pkg::IDX_W'(g)),
      .sigs_i  (sigs_r),
      .claim_i (claim),
      .tok_i   (links[g]),
      .tok_o   (links[g+1])
    );
  end

  assign moving = tail_vld_r && (!out_vld_r || out_ch.ready);

  always_comb begin
    claim.en  = moving && (tail_r.op == fst_pkg::OP_STORE) && !tail_r.hit && tail_r.free_ok;
    claim.idx = tail_r.free_idx;
    claim.key = tail_r.key;
    claim.w0  = tail_r.w0;
    claim.w1  = tail_r.w1;
    busy_nxt  = busy_r;
    if (accept) busy_nxt = 1'b1;
    if (moving) busy_nxt = 1'b0;
    tail_vld_nxt = links[fst_pkg::ENTRIES].vld ? 1'b1 : (moving ? 1'b0 : tail_vld_r);
    out_vld_nxt  = moving ? 1'b1 : ((out_vld_r && out_ch.ready) ? 1'b0 : out_vld_r);
    outcome_nxt  = outcome_r;
    count_nxt    = count_r;
    flag_nxt     = flag_r;
    if (moving) begin
      count_nxt = 2'd0;
      flag_nxt  = 1'b0;
      if (tail_r.hit) begin
        outcome_nxt = fst_pkg::OUT_OK;
        count_nxt   = tail_r.count;
        flag_nxt    = tail_r.flag;
      end else if (tail_r.op == fst_pkg::OP_STORE) begin
        outcome_nxt = tail_r.free_ok ? fst_pkg::OUT_OK : fst_pkg::OUT_FULL;
      end else begin
        outcome_nxt = fst_pkg::OUT_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      tail_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      tail_vld_r <= tail_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (links[fst_pkg::ENTRIES].vld) tail_r <= links[fst_pkg::ENTRIES];
    outcome_r <= outcome_nxt;
    count_r   <= count_nxt;
    flag_r    <= flag_nxt;
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.outcome     = outcome_r;
  assign out_ch.checks_done = count_r;
  assign out_ch.flagged     = flag_r;

  // configuration
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigs_r.first  <= fst_pkg::SIG_FIRST_RST;
      sigs_r.second <= fst_pkg::SIG_SECOND_RST;
      sigs_r.mixed  <= fst_pkg::SIG_MIXED_RST;
    end else if (cfg_wr) begin
      case (fst_pkg::reg_idx_t'(reg_idx))
        fst_pkg::REG_SIG_FIRST:  sigs_r.first  <= cfg_pwdata;
        fst_pkg::REG_SIG_SECOND: sigs_r.second <= cfg_pwdata;
        fst_pkg::REG_SIG_MIXED:  sigs_r.mixed  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (fst_pkg::reg_idx_t'(reg_idx))
      fst_pkg::REG_SIG_FIRST:  cfg_prdata = sigs_r.first;
      fst_pkg::REG_SIG_SECOND: cfg_prdata = sigs_r.second;
      fst_pkg::REG_SIG_MIXED:  cfg_prdata = sigs_r.mixed;
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready) else $error("accepted while a lookup is in flight");
  a_tail_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail_vld_r |-> busy_r) else $error("lookup result without an item in flight");
  a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (outcome_r != fst_pkg::OUT_OK)) |-> ((count_r == 2'd0) && !flag_r))
    else $error("fields set on a failed transaction");
  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (outcome_r != 2'd3)) else $error("bad outcome code");
endmodule
`default_nettype wire

@@ hw/rtl/fst_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fst_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  [fst_pkg::IDX_W-1:0]   idx_i,
  input  fst_pkg::sigs_t              sigs_i,
  input  fst_pkg::claim_t             claim_i,
  input  fst_pkg::token_t             tok_i,
  output fst_pkg::token_t             tok_o
);
  logic        valid_r, valid_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        flag_r, flag_nxt;
  logic [31:0] w0_r, w0_nxt;
  logic [31:0] w1_r, w1_nxt;
  fst_pkg::token_t tok_r, tok_nxt;
  logic match, sig_hit;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    count_nxt = count_r;
    flag_nxt  = flag_r;
    w0_nxt    = w0_r;
    w1_nxt    = w1_r;
    tok_nxt   = tok_i;
    sig_hit   = 1'b0;
    match     = tok_i.vld && valid_r && (key_r == tok_i.key);
    case (tok_i.sel)
      fst_pkg::SEL_FIRST:  sig_hit = (w0_r == sigs_i.first);
      fst_pkg::SEL_SECOND: sig_hit = (w1_r == sigs_i.second);
      fst_pkg::SEL_MIXED:  sig_hit = ((w0_r ^ w1_r) == sigs_i.mixed);
      default:             sig_hit = 1'b0;
    endcase
    if (match) begin
      case (fst_pkg::op_t'(tok_i.op))
        fst_pkg::OP_STORE: begin
          w0_nxt = tok_i.w0;
          w1_nxt = tok_i.w1;
        end
        fst_pkg::OP_CHECK: begin
          flag_nxt = flag_r | sig_hit;
          if (count_r != fst_pkg::COUNT_MAX) count_nxt = count_r + 2'd1;
        end
        fst_pkg::OP_CONSUME: valid_nxt = 1'b0;
        default: ;
      endcase
      tok_nxt.hit   = 1'b1;
      tok_nxt.count = count_nxt;
      tok_nxt.flag  = flag_nxt;
    end
    // remember the lowest free slot seen so far
    if (tok_i.vld && !valid_r && !tok_i.free_ok) begin
      tok_nxt.free_ok  = 1'b1;
      tok_nxt.free_idx = idx_i;
    end
    if (claim_i.en && (claim_i.idx == idx_i)) begin
      valid_nxt = 1'b1;
      key_nxt   = claim_i.key;
      count_nxt = 2'd0;
      flag_nxt  = 1'b0;
      w0_nxt    = claim_i.w0;
      w1_nxt    = claim_i.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    count_r <= count_nxt;
    flag_r  <= flag_nxt;
    w0_r    <= w0_nxt;
    w1_r    <= w1_nxt;
  end

  assign tok_o = tok_r;
endmodule
`default_nettype wire
